[rtl/core/i2cmrt_pkg.sv]
package i2cmrt_pkg;

  localparam int MaxTransfer = 255;

  typedef enum logic [3:0] {
    PH_IDLE, PH_INIT_WAIT, PH_START_WAIT, PH_START_FREE, PH_START_SCL,
    PH_BIT_SETUP, PH_BIT_RELEASE, PH_BIT_WAIT, PH_ACK_POLL, PH_DATA_WAIT,
    PH_STOP_A, PH_STOP_B
  } phase_t;

  typedef enum logic [1:0] {K_SEND, K_ACK, K_RECV, K_MACK} kind_t;
  typedef enum logic [1:0] {S_ADDR_W, S_REG, S_ADDR_R, S_DATA} stage_t;

  typedef enum logic [2:0] {
    ST_OK, ST_NOT_INIT, ST_ALREADY, ST_BUS_BUSY, ST_SCL_STUCK, ST_ARB_LOST,
    ST_NO_ACK, ST_INIT_LOW
  } status_t;

  typedef enum logic [2:0] {
    CFG_STRETCH, CFG_RECV_STRETCH, CFG_BUS_FREE, CFG_ACK_POLL, CFG_INIT_WAIT
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] stretch_limit;
    logic [15:0] recv_stretch_limit;
    logic [15:0] bus_free_checks;
    logic [15:0] ack_poll_limit;
    logic [15:0] init_wait_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] slave_address;
    logic [7:0] register_index;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       write_byte_valid;
    logic       scl_sample;
    logic       sda_sample;
  } tick_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic [7:0] read_byte;
    logic       read_byte_valid;
    logic       need_write_byte;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } res_t;

endpackage

[rtl/core/i2cmrt_cfg.sv]
module i2cmrt_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [15:0]       wr_data,
  output i2cmrt_pkg::cfg_t  cfg
);
  import i2cmrt_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{16'd100, 16'd256, 16'd100, 16'd100, 16'd256};
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_STRETCH:      cfg_r.stretch_limit      <= wr_data;
        CFG_RECV_STRETCH: cfg_r.recv_stretch_limit <= wr_data;
        CFG_BUS_FREE:     cfg_r.bus_free_checks    <= wr_data;
        CFG_ACK_POLL:     cfg_r.ack_poll_limit     <= wr_data;
        CFG_INIT_WAIT:    cfg_r.init_wait_limit    <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

[rtl/core/i2cmrt_seq.sv]
module i2cmrt_seq #(
  parameter int MAX_TRANSFER = i2cmrt_pkg::MaxTransfer
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  i2cmrt_pkg::tick_t tick,
  input  i2cmrt_pkg::cfg_t  cfg,
  output i2cmrt_pkg::res_t  res
);
  import i2cmrt_pkg::*;

  localparam logic [7:0] MaxCnt = (MAX_TRANSFER > 255) ? 8'd255 : 8'(MAX_TRANSFER);

  phase_t phase_r, phase_nxt;
  kind_t kind_r, kind_nxt;
  stage_t stage_r, stage_nxt;
  logic init_r, init_nxt, rd_r, rd_nxt, scl_r, scl_nxt, sda_r, sda_nxt;
  logic rst_pend_r, rst_pend_nxt;
  status_t end_st_r, end_st_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [7:0] reg_r, reg_nxt, sh_r, sh_nxt, left_r, left_nxt;
  logic [2:0] bitp_r, bitp_nxt;
  logic [15:0] poll_r, poll_nxt, poll_inc, limit;
  logic done, rbv, cur_bit, both_hi;
  status_t st;
  logic [7:0] rb;

  // zero limit behaves like one: counter reaches it after one increment
  function automatic logic hit(input logic [15:0] c, input logic [15:0] l);
    return {1'b0, c} + 17'd1 >= {1'b0, l};
  endfunction

  assign poll_inc = poll_r + 16'd1;
  assign cur_bit  = sh_r[bitp_r];
  assign both_hi  = tick.scl_sample && tick.sda_sample;
  assign limit    = (kind_r == K_RECV) ? cfg.recv_stretch_limit : cfg.stretch_limit;

  always_comb begin
    phase_nxt = phase_r; kind_nxt = kind_r; stage_nxt = stage_r;
    init_nxt = init_r; rd_nxt = rd_r; scl_nxt = scl_r; sda_nxt = sda_r;
    rst_pend_nxt = rst_pend_r; end_st_nxt = end_st_r; addr_nxt = addr_r;
    reg_nxt = reg_r; sh_nxt = sh_r; left_nxt = left_r; bitp_nxt = bitp_r;
    poll_nxt = poll_r; done = 1'b0; st = ST_OK; rb = '0; rbv = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (tick.req_type == 2'd1) begin
          if (init_r) begin
            done = 1'b1; st = ST_ALREADY;
          end else begin
            scl_nxt = 1'b0; sda_nxt = 1'b0; poll_nxt = '0; phase_nxt = PH_INIT_WAIT;
          end
        end else if (tick.req_type[1]) begin
          if (!init_r) begin
            done = 1'b1; st = ST_NOT_INIT;
          end else begin
            addr_nxt = tick.slave_address; reg_nxt = tick.register_index;
            left_nxt = (tick.byte_count > MaxCnt) ? MaxCnt : tick.byte_count;
            rd_nxt = tick.req_type[0]; stage_nxt = S_ADDR_W;
            scl_nxt = 1'b0; sda_nxt = 1'b0; poll_nxt = '0; phase_nxt = PH_START_WAIT;
          end
        end
      end
      PH_INIT_WAIT: begin
        if (both_hi) begin
          init_nxt = 1'b1; done = 1'b1; phase_nxt = PH_IDLE;
        end else begin
          poll_nxt = poll_inc;
          if (hit(poll_r, cfg.init_wait_limit)) begin
            done = 1'b1; st = ST_INIT_LOW; phase_nxt = PH_IDLE;
          end
        end
      end
      PH_START_WAIT: begin
        if (both_hi) begin
          poll_nxt = '0; phase_nxt = PH_START_FREE;
        end else begin
          poll_nxt = poll_inc;
          if (hit(poll_r, cfg.stretch_limit)) begin
            done = 1'b1; st = ST_BUS_BUSY; phase_nxt = PH_IDLE;
          end
        end
      end
      PH_START_FREE: begin
        if (!both_hi) begin
          done = 1'b1; st = ST_BUS_BUSY; phase_nxt = PH_IDLE;
        end else begin
          poll_nxt = poll_inc;
          if (hit(poll_r, cfg.bus_free_checks)) begin
            sda_nxt = 1'b1; phase_nxt = PH_START_SCL;
          end
        end
      end
      PH_START_SCL: begin
        if (!tick.scl_sample) begin
          scl_nxt = 1'b0; sda_nxt = 1'b0; done = 1'b1; st = ST_SCL_STUCK;
          phase_nxt = PH_IDLE;
        end else begin
          scl_nxt = 1'b1; sh_nxt = {addr_r, stage_r == S_ADDR_R};
          bitp_nxt = 3'd7; kind_nxt = K_SEND; phase_nxt = PH_BIT_SETUP;
        end
      end
      PH_BIT_SETUP: begin
        scl_nxt = 1'b1;
        case (kind_r)
          K_SEND:  sda_nxt = !cur_bit;
          K_MACK:  sda_nxt = (left_r != 8'd0);
          default: sda_nxt = 1'b0;
        endcase
        phase_nxt = PH_BIT_RELEASE;
      end
      PH_BIT_RELEASE: begin
        scl_nxt = 1'b0; poll_nxt = '0; phase_nxt = PH_BIT_WAIT;
      end
      PH_BIT_WAIT: begin
        if (tick.scl_sample) begin
          case (kind_r)
            K_SEND: begin
              if (tick.sda_sample != cur_bit) begin
                scl_nxt = 1'b0; sda_nxt = 1'b0; done = 1'b1; st = ST_ARB_LOST;
                phase_nxt = PH_IDLE;
              end else begin
                scl_nxt = 1'b1; phase_nxt = PH_BIT_SETUP;
                if (bitp_r == 3'd0) kind_nxt = K_ACK;
                else bitp_nxt = bitp_r - 3'd1;
              end
            end
            K_ACK: begin
              poll_nxt = '0; phase_nxt = PH_ACK_POLL;
            end
            K_RECV: begin
              sh_nxt = {sh_r[6:0], tick.sda_sample}; scl_nxt = 1'b1;
              phase_nxt = PH_BIT_SETUP;
              if (bitp_r == 3'd0) begin
                rb = sh_nxt; rbv = 1'b1;
                if (left_r != 8'd0) left_nxt = left_r - 8'd1;
                kind_nxt = K_MACK;
              end else begin
                bitp_nxt = bitp_r - 3'd1;
              end
            end
            default: begin
              scl_nxt = 1'b1;
              if (left_r != 8'd0) begin
                sh_nxt = '0; bitp_nxt = 3'd7; kind_nxt = K_RECV; phase_nxt = PH_BIT_SETUP;
              end else begin
                sda_nxt = 1'b1; end_st_nxt = ST_OK; rst_pend_nxt = 1'b0;
                phase_nxt = PH_STOP_A;
              end
            end
          endcase
        end else begin
          poll_nxt = poll_inc;
          if (hit(poll_r, limit)) begin
            if (kind_r == K_MACK) begin
              scl_nxt = 1'b1;
              if (left_r != 8'd0) begin
                sh_nxt = '0; bitp_nxt = 3'd7; kind_nxt = K_RECV; phase_nxt = PH_BIT_SETUP;
              end else begin
                sda_nxt = 1'b1; end_st_nxt = ST_OK; rst_pend_nxt = 1'b0;
                phase_nxt = PH_STOP_A;
              end
            end else begin
              sda_nxt = 1'b1; end_st_nxt = ST_SCL_STUCK; rst_pend_nxt = 1'b0;
              phase_nxt = PH_STOP_A;
            end
          end
        end
      end
      PH_ACK_POLL: begin
        if (!tick.sda_sample) begin
          scl_nxt = 1'b1;
          case (stage_r)
            S_ADDR_W: begin
              stage_nxt = S_REG; sh_nxt = reg_r; bitp_nxt = 3'd7; kind_nxt = K_SEND;
              phase_nxt = PH_BIT_SETUP;
            end
            S_REG: begin
              if (rd_r) begin
                sda_nxt = 1'b1; end_st_nxt = ST_OK; rst_pend_nxt = 1'b1;
                phase_nxt = PH_STOP_A;
              end else begin
                stage_nxt = S_DATA;
                if (left_r == 8'd0) begin
                  sda_nxt = 1'b1; end_st_nxt = ST_OK; rst_pend_nxt = 1'b0;
                  phase_nxt = PH_STOP_A;
                end else phase_nxt = PH_DATA_WAIT;
              end
            end
            S_ADDR_R: begin
              stage_nxt = S_DATA;
              if (left_r != 8'd0) begin
                sh_nxt = '0; bitp_nxt = 3'd7; kind_nxt = K_RECV; phase_nxt = PH_BIT_SETUP;
              end else begin
                sda_nxt = 1'b1; end_st_nxt = ST_OK; rst_pend_nxt = 1'b0;
                phase_nxt = PH_STOP_A;
              end
            end
            default: begin
              if (left_r <= 8'd1) begin
                left_nxt = '0;
                sda_nxt = 1'b1; end_st_nxt = ST_OK; rst_pend_nxt = 1'b0;
                phase_nxt = PH_STOP_A;
              end else begin
                left_nxt = left_r - 8'd1; phase_nxt = PH_DATA_WAIT;
              end
            end
          endcase
        end else begin
          poll_nxt = poll_inc;
          if (hit(poll_r, cfg.ack_poll_limit)) begin
            scl_nxt = 1'b1; sda_nxt = 1'b1; end_st_nxt = ST_NO_ACK; rst_pend_nxt = 1'b0;
            phase_nxt = PH_STOP_A;
          end
        end
      end
      PH_DATA_WAIT: begin
        if (tick.write_byte_valid) begin
          sh_nxt = tick.write_byte; bitp_nxt = 3'd7; kind_nxt = K_SEND;
          phase_nxt = PH_BIT_SETUP;
        end
      end
      PH_STOP_A: begin
        scl_nxt = 1'b0; phase_nxt = PH_STOP_B;
      end
      PH_STOP_B: begin
        sda_nxt = 1'b0;
        if (rst_pend_r) begin
          rst_pend_nxt = 1'b0; stage_nxt = S_ADDR_R; poll_nxt = '0;
          phase_nxt = PH_START_WAIT;
        end else begin
          done = 1'b1; st = end_st_r; phase_nxt = PH_IDLE;
        end
      end
      default: begin
        scl_nxt = 1'b0; sda_nxt = 1'b0; phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; kind_r <= K_SEND; stage_r <= S_ADDR_W;
      init_r <= 1'b0; rd_r <= 1'b0; scl_r <= 1'b0; sda_r <= 1'b0;
      rst_pend_r <= 1'b0; end_st_r <= ST_OK; addr_r <= '0; reg_r <= '0;
      sh_r <= '0; left_r <= '0; bitp_r <= 3'd7; poll_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; kind_r <= kind_nxt; stage_r <= stage_nxt;
      init_r <= init_nxt; rd_r <= rd_nxt; scl_r <= scl_nxt; sda_r <= sda_nxt;
      rst_pend_r <= rst_pend_nxt; end_st_r <= end_st_nxt; addr_r <= addr_nxt;
      reg_r <= reg_nxt; sh_r <= sh_nxt; left_r <= left_nxt; bitp_r <= bitp_nxt;
      poll_r <= poll_nxt;
    end
  end

  always_comb begin
    res.scl_pull_low    = scl_nxt;
    res.sda_pull_low    = sda_nxt;
    res.read_byte       = rb;
    res.read_byte_valid = rbv;
    res.need_write_byte = (phase_nxt == PH_DATA_WAIT);
    res.busy_res        = (phase_nxt != PH_IDLE);
    res.done_res        = done;
    res.status          = st;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && done |=> phase_r == PH_IDLE)
    else $error("done without return to idle");
  a_stop_seq: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_STOP_A |=> phase_r == PH_STOP_B)
    else $error("stop sequence broken");
  a_rbv_mack: assert property (@(posedge clk) disable iff (!rst_n)
    step && rbv |=> kind_r == K_MACK)
    else $error("byte received without master ack");
endmodule

[rtl/core/i2c_master_register_transfer_top.sv]
// The result beat is registered: it appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output is not stalled; the sequencer registers step once per tick.
// The result register frees up when taken, so input keeps flowing while it is read.
// Reset (rst_n low, synchronous): sequencer idle, not initialised, lines released,
// limits at their default values, no result pending.
module i2c_master_register_transfer_top #(
  parameter int MAX_TRANSFER = i2cmrt_pkg::MaxTransfer
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type[1:0], slave_address[8:2], register_index[16:9], byte_count[24:17],
  // write_byte[32:25], write_byte_valid[33], scl_sample[34], sda_sample[35]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_pull_low[0], sda_pull_low[1], read_byte[9:2], read_byte_valid[10],
  // need_write_byte[11], busy_res[12], done_res[13], status[16:14]
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import i2cmrt_pkg::*;

  tick_t tick;
  cfg_t cfg;
  res_t res;
  logic step;
  logic vld_r;
  logic [16:0] dat_r;

  assign in_tready = !vld_r || out_tready;
  assign step = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign tick = '{in_tdata[1:0], in_tdata[8:2], in_tdata[16:9], in_tdata[24:17],
                  in_tdata[32:25], in_tdata[33], in_tdata[34], in_tdata[35]};

  i2cmrt_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .wr_en(cfg_valid), .wr_index(cfg_index),
    .wr_data(cfg_data), .cfg(cfg)
  );

  i2cmrt_seq #(.MAX_TRANSFER(MAX_TRANSFER)) u_seq (
    .clk(clk), .rst_n(rst_n), .step(step), .tick(tick), .cfg(cfg), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (step) begin
      dat_r <= {res.status, res.done_res, res.busy_res, res.need_write_byte,
                res.read_byte_valid, res.read_byte, res.sda_pull_low, res.scl_pull_low};
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata = {7'd0, dat_r};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("accepted beat without result");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");
endmodule

[tb/i2c_transfer_checker.sv]
`timescale 1ns / 100ps

module i2c_transfer_checker
  import i2cmrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          pending
);

  res_t        line_q[$];

  int unsigned lim_stretch, lim_recv, lim_free, lim_ack, lim_init;
  phase_t      ph;
  kind_t       knd;
  stage_t      stg;
  status_t     end_st;
  bit          inited, rd, restart, scl_o, sda_o;
  logic [6:0]  addr;
  logic [7:0]  regi, shb, left;
  logic [2:0]  bpos;
  int unsigned pcnt;
  // per-tick outputs
  bit          done_f, rbv_f;
  status_t     st_f;
  logic [7:0]  rb_f;

  initial fails = 0;
  initial pending = 0;

  task automatic report(input string what, input int got, input int exp_v);
    $display("error: %s got %0d, expected %0d at %0t", what, got, exp_v, $time);
    fails++;
  endtask

  function automatic void seq_reset();
    lim_stretch = 100; lim_recv = 256; lim_free = 100; lim_ack = 100; lim_init = 256;
    ph = PH_IDLE; knd = K_SEND; stg = S_ADDR_W; end_st = ST_OK;
    inited = 0; rd = 0; restart = 0; scl_o = 0; sda_o = 0;
    addr = '0; regi = '0; shb = '0; left = '0; bpos = 3'd7; pcnt = 0;
  endfunction

  function automatic void finish_req(input status_t st);
    ph = PH_IDLE;
    done_f = 1;
    st_f = st;
  endfunction

  function automatic void begin_stop(input status_t st, input bit rs);
    sda_o = 1;
    end_st = st;
    restart = rs;
    ph = PH_STOP_A;
  endfunction

  function automatic void begin_send(input logic [7:0] b);
    shb = b;
    bpos = 3'd7;
    knd = K_SEND;
    ph = PH_BIT_SETUP;
  endfunction

  function automatic void begin_recv();
    shb = '0;
    bpos = 3'd7;
    knd = K_RECV;
    ph = PH_BIT_SETUP;
  endfunction

  function automatic void write_next();
    if (left == 0) begin_stop(ST_OK, 0);
    else ph = PH_DATA_WAIT;
  endfunction

  function automatic void after_mack();
    if (left != 0) begin_recv();
    else begin_stop(ST_OK, 0);
  endfunction

  function automatic res_t line_step(input tick_t t);
    res_t        r;
    int unsigned limit;
    done_f = 0; rbv_f = 0; st_f = ST_OK; rb_f = '0;
    case (ph)
      PH_IDLE: begin
        if (t.req_type == 2'd1) begin
          if (inited) finish_req(ST_ALREADY);
          else begin
            scl_o = 0; sda_o = 0; pcnt = 0; ph = PH_INIT_WAIT;
          end
        end else if (t.req_type >= 2'd2) begin
          if (!inited) finish_req(ST_NOT_INIT);
          else begin
            addr = t.slave_address;
            regi = t.register_index;
            left = (t.byte_count > MaxTransfer) ? 8'(MaxTransfer) : t.byte_count;
            rd = (t.req_type == 2'd3);
            stg = S_ADDR_W;
            scl_o = 0; sda_o = 0; pcnt = 0; ph = PH_START_WAIT;
          end
        end
      end
      PH_INIT_WAIT: begin
        if (t.scl_sample && t.sda_sample) begin
          inited = 1;
          finish_req(ST_OK);
        end else begin
          pcnt++;
          if (pcnt >= lim_init) finish_req(ST_INIT_LOW);
        end
      end
      PH_START_WAIT: begin
        if (t.scl_sample && t.sda_sample) begin
          pcnt = 0;
          ph = PH_START_FREE;
        end else begin
          pcnt++;
          if (pcnt >= lim_stretch) finish_req(ST_BUS_BUSY);
        end
      end
      PH_START_FREE: begin
        if (!(t.scl_sample && t.sda_sample)) finish_req(ST_BUS_BUSY);
        else begin
          pcnt++;
          if (pcnt >= lim_free) begin
            sda_o = 1;
            ph = PH_START_SCL;
          end
        end
      end
      PH_START_SCL: begin
        if (!t.scl_sample) begin
          scl_o = 0; sda_o = 0;
          finish_req(ST_SCL_STUCK);
        end else begin
          scl_o = 1;
          begin_send({addr, stg == S_ADDR_R});
        end
      end
      PH_BIT_SETUP: begin
        scl_o = 1;
        if (knd == K_SEND) sda_o = !shb[bpos];
        else if (knd == K_MACK) sda_o = (left != 0);
        else sda_o = 0;
        ph = PH_BIT_RELEASE;
      end
      PH_BIT_RELEASE: begin
        scl_o = 0;
        pcnt = 0;
        ph = PH_BIT_WAIT;
      end
      PH_BIT_WAIT: begin
        limit = (knd == K_RECV) ? lim_recv : lim_stretch;
        if (t.scl_sample) begin
          case (knd)
            K_SEND: begin
              if (t.sda_sample != shb[bpos]) begin
                // arbitration lost: let go of both lines at once
                scl_o = 0; sda_o = 0;
                finish_req(ST_ARB_LOST);
              end else begin
                scl_o = 1;
                if (bpos == 0) knd = K_ACK;
                else bpos--;
                ph = PH_BIT_SETUP;
              end
            end
            K_ACK: begin
              pcnt = 0;
              ph = PH_ACK_POLL;
            end
            K_RECV: begin
              shb = {shb[6:0], t.sda_sample};
              scl_o = 1;
              if (bpos == 0) begin
                rb_f = shb;
                rbv_f = 1;
                if (left != 0) left--;
                knd = K_MACK;
              end else bpos--;
              ph = PH_BIT_SETUP;
            end
            default: begin
              scl_o = 1;
              after_mack();
            end
          endcase
        end else begin
          pcnt++;
          if (pcnt >= limit) begin
            // a stuck clock during our own ACK/NAK is ignored
            if (knd == K_MACK) begin
              scl_o = 1;
              after_mack();
            end else begin_stop(ST_SCL_STUCK, 0);
          end
        end
      end
      PH_ACK_POLL: begin
        if (!t.sda_sample) begin
          scl_o = 1;
          case (stg)
            S_ADDR_W: begin
              stg = S_REG;
              begin_send(regi);
            end
            S_REG: begin
              if (rd) begin_stop(ST_OK, 1);
              else begin
                stg = S_DATA;
                write_next();
              end
            end
            S_ADDR_R: begin
              stg = S_DATA;
              if (left != 0) begin_recv();
              else begin_stop(ST_OK, 0);
            end
            default: begin
              if (left != 0) left--;
              write_next();
            end
          endcase
        end else begin
          pcnt++;
          if (pcnt >= lim_ack) begin
            scl_o = 1;
            begin_stop(ST_NO_ACK, 0);
          end
        end
      end
      PH_DATA_WAIT: begin
        if (t.write_byte_valid) begin_send(t.write_byte);
      end
      PH_STOP_A: begin
        scl_o = 0;
        ph = PH_STOP_B;
      end
      PH_STOP_B: begin
        sda_o = 0;
        if (restart) begin
          restart = 0;
          stg = S_ADDR_R;
          pcnt = 0;
          ph = PH_START_WAIT;
        end else finish_req(end_st);
      end
      default: begin
        scl_o = 0; sda_o = 0;
        ph = PH_IDLE;
      end
    endcase
    r.scl_pull_low    = scl_o;
    r.sda_pull_low    = sda_o;
    r.read_byte       = rb_f;
    r.read_byte_valid = rbv_f;
    r.need_write_byte = (ph == PH_DATA_WAIT);
    r.busy_res        = (ph != PH_IDLE);
    r.done_res        = done_f;
    r.status          = st_f;
    return r;
  endfunction

  always @(posedge clk) begin
    tick_t t;
    res_t  g, e;
    if (!rst_n) begin
      seq_reset();
      line_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        g.scl_pull_low    = out_tdata[0];
        g.sda_pull_low    = out_tdata[1];
        g.read_byte       = out_tdata[9:2];
        g.read_byte_valid = out_tdata[10];
        g.need_write_byte = out_tdata[11];
        g.busy_res        = out_tdata[12];
        g.done_res        = out_tdata[13];
        g.status          = out_tdata[16:14];
        if (line_q.size() == 0) report("result beat with nothing expected", 0, 0);
        else begin
          e = line_q.pop_front();
          if (g.scl_pull_low != e.scl_pull_low) report("scl_pull_low", g.scl_pull_low, e.scl_pull_low);
          if (g.sda_pull_low != e.sda_pull_low) report("sda_pull_low", g.sda_pull_low, e.sda_pull_low);
          if (g.read_byte != e.read_byte) report("read_byte", g.read_byte, e.read_byte);
          if (g.read_byte_valid != e.read_byte_valid)
            report("read_byte_valid", g.read_byte_valid, e.read_byte_valid);
          if (g.need_write_byte != e.need_write_byte)
            report("need_write_byte", g.need_write_byte, e.need_write_byte);
          if (g.busy_res != e.busy_res) report("busy_res", g.busy_res, e.busy_res);
          if (g.done_res != e.done_res) report("done_res", g.done_res, e.done_res);
          if (g.status != e.status) report("status", g.status, e.status);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_STRETCH:      lim_stretch = cfg_data;
          CFG_RECV_STRETCH: lim_recv = cfg_data;
          CFG_BUS_FREE:     lim_free = cfg_data;
          CFG_ACK_POLL:     lim_ack = cfg_data;
          CFG_INIT_WAIT:    lim_init = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        t.req_type         = in_tdata[1:0];
        t.slave_address    = in_tdata[8:2];
        t.register_index   = in_tdata[16:9];
        t.byte_count       = in_tdata[24:17];
        t.write_byte       = in_tdata[32:25];
        t.write_byte_valid = in_tdata[33];
        t.scl_sample       = in_tdata[34];
        t.sda_sample       = in_tdata[35];
        line_q.push_back(line_step(t));
      end
    end
    pending = line_q.size();
  end

endmodule

[tb/tb_i2c_master_register_transfer_top.sv]
`timescale 1ns / 100ps

module tb_i2c_master_register_transfer_top;
  import i2cmrt_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fails;
  int          pending;

  // view of the bus as left by the last result beat
  bit scl_d, sda_d, busy_q, need_q, rd_req, drain;
  int bitcnt, byte_no, starts;
  int send_run, take_run;

  i2c_master_register_transfer_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  i2c_transfer_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // gap drawn from 0..5, with occasional runs of back-to-back beats
  function automatic int draw_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) run = $urandom_range(5, 30);
    return $urandom_range(0, 5);
  endfunction

  initial begin
    int w;
    out_tready = 0;
    take_run = 0;
    wait (rst_n === 1'b1);
    forever begin
      w = draw_gap(take_run);
      if (w != 0) begin
        out_tready <= 0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_tick(input logic [1:0] req, input logic [6:0] a, input logic [7:0] r,
                           input logic [7:0] c, input logic [7:0] wb, input bit wv,
                           input bit scl, input bit sda);
    int w;
    logic [23:0] res;
    bit nscl, nsda;
    w = draw_gap(send_run);
    if (w != 0) repeat (w) @(posedge clk);
    in_tvalid <= 1;
    in_tdata  <= {4'b0, sda, scl, wv, wb, c, r, a, req};
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 0;
    // hold the next tick until this one's line drive is known
    do @(posedge clk); while (!(out_tvalid && out_tready));
    res = out_tdata;
    nscl = res[0];
    nsda = res[1];
    if (scl_d && !nscl) begin
      bitcnt++;
      if (bitcnt > 9) begin
        bitcnt = 1;
        byte_no++;
      end
    end
    if (!sda_d && nsda && !nscl) begin
      starts++;
      bitcnt = 0;
      byte_no = 0;
    end
    scl_d = nscl;
    sda_d = nsda;
    need_q = res[11];
    busy_q = res[12];
    if (res[13]) starts = 0;
  endtask

  // tick with line samples from a simple slave: acks bytes it receives and
  // drives data bits of read bytes, with some clock stretching and noise
  task automatic bus_tick(input logic [1:0] req, input logic [6:0] a, input logic [7:0] r,
                          input logic [7:0] c);
    bit rd_data, slave_low, scl, sda, wv;
    if (!busy_q && req >= 2'd2) rd_req = (req == 2'd3);
    rd_data = rd_req && starts >= 2 && byte_no >= 1;
    slave_low = 0;
    if (bitcnt == 9 && !rd_data) slave_low = !drain && ($urandom_range(0, 15) != 0);
    else if (rd_data && bitcnt >= 1 && bitcnt <= 8) slave_low = ($urandom_range(0, 1) != 0);
    scl = !scl_d && ($urandom_range(0, 19) != 0);
    sda = !sda_d && !slave_low;
    if ($urandom_range(0, 49) == 0) sda = !sda;
    wv = need_q ? (drain || $urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
    send_tick(req, a, r, c, 8'($urandom_range(0, 255)), wv, scl, sda);
  endtask

  task automatic xfer(input logic [1:0] req, input logic [6:0] a, input logic [7:0] r,
                      input logic [7:0] c);
    bus_tick(req, a, r, c);
    while (busy_q) bus_tick(2'd0, 7'd0, 8'd0, 8'd0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic set_limits(input logic [15:0] s, input logic [15:0] rcv,
                            input logic [15:0] fr, input logic [15:0] ak,
                            input logic [15:0] it);
    // finish any transfer with a silent slave, then let the result register drain
    drain = 1;
    while (busy_q) bus_tick(2'd0, 7'd0, 8'd0, 8'd0);
    drain = 0;
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(CFG_STRETCH, s);
    write_reg(CFG_RECV_STRETCH, rcv);
    write_reg(CFG_BUS_FREE, fr);
    write_reg(CFG_ACK_POLL, ak);
    write_reg(CFG_INIT_WAIT, it);
  endtask

  task automatic random_ticks(input int n, input bit with_xfer);
    int k;
    logic [1:0] req;
    logic [7:0] c;
    for (k = 0; k < n; k++) begin
      if (!busy_q) begin
        case ($urandom_range(0, 9))
          0, 1, 2: req = 2'd0;
          3:       req = 2'd1;
          4, 5, 6: req = 2'd2;
          default: req = 2'd3;
        endcase
        if (!with_xfer && req >= 2'd2) req = 2'd0;
      end else begin
        req = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
      end
      c = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
      bus_tick(req, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), c);
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    scl_d = 0; sda_d = 0; busy_q = 0; need_q = 0; rd_req = 0; drain = 0;
    bitcnt = 0; byte_no = 0; starts = 0; send_run = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_limits(16'd3, 16'd4, 16'd2, 16'd3, 16'd2);
    // requests before init, init against low lines, init twice
    send_tick(2'd3, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1);
    send_tick(2'd2, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
    send_tick(2'd1, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(2'd0, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
    send_tick(2'd0, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
    send_tick(2'd1, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
    send_tick(2'd0, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
    send_tick(2'd1, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
    // zero-length write and read, then short ones
    xfer(2'd2, 7'h7f, 8'hff, 8'd0);
    xfer(2'd3, 7'h00, 8'h00, 8'd0);
    xfer(2'd2, 7'h55, 8'haa, 8'd2);
    xfer(2'd3, 7'h2a, 8'h55, 8'd3);

    random_ticks(300, 1'b1);
    set_limits(16'd8, 16'd20, 16'd1, 16'd10, 16'd65535);
    random_ticks(250, 1'b1);
    set_limits(16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd1);
    random_ticks(30, 1'b0);
    set_limits(16'd0, 16'd1, 16'd1, 16'd1, 16'd1);
    random_ticks(200, 1'b1);
    set_limits(16'd5, 16'd12, 16'd4, 16'd6, 16'd300);
    random_ticks(200, 1'b1);

    drain = 1;
    while (busy_q) bus_tick(2'd0, 7'd0, 8'd0, 8'd0);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
rtl/core/i2cmrt_pkg.sv
rtl/core/i2cmrt_cfg.sv
rtl/core/i2cmrt_seq.sv
rtl/core/i2c_master_register_transfer_top.sv
tb/i2c_transfer_checker.sv
tb/tb_i2c_master_register_transfer_top.sv
